FILE: rtl/torus_grid_random_walker_macros.svh
// ---------------------------------------------------------------------------
// torus grid random walker assertion macros
// shared concurrent assertion forms for the walker checker
// ---------------------------------------------------------------------------
`ifndef TORUS_GRID_RANDOM_WALKER_MACROS_SVH
`define TORUS_GRID_RANDOM_WALKER_MACROS_SVH

// property checked outside reset
`define TGRW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define TGRW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tgrw_pkg.sv
// ---------------------------------------------------------------------------
// tgrw_pkg
// types, field widths and reset values of the torus grid random walker
// ---------------------------------------------------------------------------
package tgrw_pkg;

   localparam int MAX_SIDE_DEF   = 64;
   localparam int COUNT_BITS_DEF = 16;

   // item field widths
   localparam int OP_W    = 2;
   localparam int CELL_W  = 6;
   localparam int DRAW_W  = 7;
   localparam int OUT_CNT_W = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SIDE_REG_W = 7;
   localparam int PCT_W      = 7;
   localparam int LIMIT_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT_DOWN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT_UP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT_LEFT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW    = 3'd7;

   localparam int RST_GRID_WIDTH  = 64;
   localparam int RST_GRID_HEIGHT = 64;
   localparam int RST_PERCENT     = 25;
   localparam int RST_STEP_LIMIT  = 1000;
   localparam int RST_START_COL   = 10;
   localparam int RST_START_ROW   = 10;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_OBSTACLE = 2'd0,
      OP_STEP           = 2'd1,
      OP_RESTART        = 2'd2,
      OP_QUERY          = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0]    col_now;
      logic [CELL_W-1:0]    row_now;
      logic                 moved;
      logic                 reached_goal;
      logic                 walk_over;
      logic [OUT_CNT_W-1:0] moves_made;
      logic [OUT_CNT_W-1:0] walks_ended;
      logic [OUT_CNT_W-1:0] walks_won;
      logic                 query_blocked;
      logic                 query_visited;
   } rsp_data_type;

endpackage

FILE: rtl/tgrw_if.sv
// ---------------------------------------------------------------------------
// tgrw channel interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface tgrw_req_if import tgrw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CELL_W-1:0] cell_col;
   logic [CELL_W-1:0] cell_row;
   logic              cell_blocked;
   logic [DRAW_W-1:0] draw;

   modport source (
      output valid, operation, cell_col, cell_row, cell_blocked, draw,
      input  ready
   );
   modport sink (
      input  valid, operation, cell_col, cell_row, cell_blocked, draw,
      output ready
   );
endinterface

interface tgrw_rsp_if import tgrw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CELL_W-1:0]    col_now;
   logic [CELL_W-1:0]    row_now;
   logic                 moved;
   logic                 reached_goal;
   logic                 walk_over;
   logic [OUT_CNT_W-1:0] moves_made;
   logic [OUT_CNT_W-1:0] walks_ended;
   logic [OUT_CNT_W-1:0] walks_won;
   logic                 query_blocked;
   logic                 query_visited;

   modport source (
      output valid, col_now, row_now, moved, reached_goal, walk_over, moves_made,
             walks_ended, walks_won, query_blocked, query_visited,
      input  ready
   );
   modport sink (
      input  valid, col_now, row_now, moved, reached_goal, walk_over, moves_made,
             walks_ended, walks_won, query_blocked, query_visited,
      output ready
   );
endinterface

FILE: rtl/torus_grid_random_walker.sv
// ---------------------------------------------------------------------------
// torus_grid_random_walker
// random walk of one point over a wrapping grid with an obstacle map
// ---------------------------------------------------------------------------
// Obstacle writes, queries and most steps are accepted in ST_IDLE, where the
// memory read is issued, and complete in ST_FINISH. A restart passes through
// ST_DIVIDE before ST_FINISH, and a step along an axis on which the walker
// stands outside a shrunken grid through ST_DIVIDE and ST_LOOKUP (a decrement
// from one past the last column or row excepted): the wrap is then reduced by
// a bit-serial remainder unit over DW = max(6, clog2(MAX_SIDE+1)) dividend
// bits, 7 by default, one bit per cycle. ST_FINISH waits for as long as an
// earlier result sits untaken in the output register. The obstacle and visited
// maps are memories of MAX_SIDE*MAX_SIDE bits with one write port and a
// registered read; after reset a clearing pass over every cell runs before the
// first item is taken, while configuration writes are accepted throughout. A
// new item is taken while a result still waits in the output register.
// ---------------------------------------------------------------------------
module torus_grid_random_walker import tgrw_pkg::*; #(
   parameter int MAX_SIDE   = MAX_SIDE_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tgrw_req_if.sink              req_if,
   tgrw_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int KW    = SW + 1;
   localparam int RW    = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
   localparam int QW    = (SW > CELL_W) ? SW : CELL_W;
   localparam int DW    = (SW > CELL_W) ? SW : CELL_W;
   localparam int ITW   = $clog2(DW + 1);
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

   localparam int EFF_W_RST = (RST_GRID_WIDTH > MAX_SIDE) ? MAX_SIDE : RST_GRID_WIDTH;
   localparam int EFF_H_RST = (RST_GRID_HEIGHT > MAX_SIDE) ? MAX_SIDE : RST_GRID_HEIGHT;
   localparam logic [CW-1:0] WALKER_COL_RST = CW'(RST_START_COL % EFF_W_RST);
   localparam logic [CW-1:0] WALKER_ROW_RST = CW'(RST_START_ROW % EFF_H_RST);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] c, logic [CW-1:0] r);
      return AW'(r) * AW'(MAX_SIDE) + AW'(c);
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // configuration registers
   logic [SIDE_REG_W-1:0] grid_width_ff, grid_height_ff;
   logic [PCT_W-1:0]      pct_down_ff, pct_up_ff, pct_left_ff;
   logic [LIMIT_W-1:0]    step_limit_ff;
   logic [CELL_W-1:0]     start_col_ff, start_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIDE_REG_W'(RST_GRID_WIDTH);
         grid_height_ff <= SIDE_REG_W'(RST_GRID_HEIGHT);
         pct_down_ff    <= PCT_W'(RST_PERCENT);
         pct_up_ff      <= PCT_W'(RST_PERCENT);
         pct_left_ff    <= PCT_W'(RST_PERCENT);
         step_limit_ff  <= LIMIT_W'(RST_STEP_LIMIT);
         start_col_ff   <= CELL_W'(RST_START_COL);
         start_row_ff   <= CELL_W'(RST_START_ROW);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:   grid_width_ff  <= csr_wr_data[SIDE_REG_W-1:0];
            CSR_GRID_HEIGHT:  grid_height_ff <= csr_wr_data[SIDE_REG_W-1:0];
            CSR_PERCENT_DOWN: pct_down_ff    <= csr_wr_data[PCT_W-1:0];
            CSR_PERCENT_UP:   pct_up_ff      <= csr_wr_data[PCT_W-1:0];
            CSR_PERCENT_LEFT: pct_left_ff    <= csr_wr_data[PCT_W-1:0];
            CSR_STEP_LIMIT:   step_limit_ff  <= csr_wr_data[LIMIT_W-1:0];
            CSR_START_COL:    start_col_ff   <= csr_wr_data[CELL_W-1:0];
            CSR_START_ROW:    start_row_ff   <= csr_wr_data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   // effective grid size, zero acts as one and large values clamp
   logic [RW-1:0] gw_ext, gh_ext;
   logic [SW-1:0] eff_w, eff_h;

   always_comb begin
      gw_ext = RW'(grid_width_ff);
      gh_ext = RW'(grid_height_ff);
      if (gw_ext == '0)                 eff_w = SW'(1);
      else if (gw_ext > RW'(MAX_SIDE)) eff_w = SW'(MAX_SIDE);
      else                              eff_w = SW'(gw_ext);
      if (gh_ext == '0)                 eff_h = SW'(1);
      else if (gh_ext > RW'(MAX_SIDE)) eff_h = SW'(MAX_SIDE);
      else                              eff_h = SW'(gh_ext);
   end

   // walk state
   logic [CW-1:0]         walker_col_ff, walker_row_ff, walker_col_in, walker_row_in;
   logic [COUNT_BITS-1:0] move_count_ff, move_count_in;
   logic                  goal_ff, goal_in, ended_ff, ended_in;
   logic [COUNT_BITS-1:0] ended_total_ff, ended_total_in, won_total_ff, won_total_in;

   // item held while it is worked on
   op_type        op_ff;
   logic          blk_ff, q_ok_ff, axis_col_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] tgt_col_ff, tgt_row_ff;

   // remainder unit
   logic [DW-1:0]  dvd_col_ff, dvd_row_ff;
   logic [SW-1:0]  rem_col_ff, rem_row_ff, rem_col_nx, rem_row_nx;
   logic [SW:0]    sh_col, sh_row;
   logic [ITW-1:0] iter_ff, iter_in;
   logic           div_last;

   // control
   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        clr_last, acc, fin_fire, out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // memories
   logic          obs_mem [CELLS];
   logic          vis_mem [CELLS];
   logic          obs_rd_ff, vis_rd_ff;
   logic [AW-1:0] rd_addr, obs_wr_addr, vis_wr_addr;
   logic          obs_wr_en, obs_wr_data, vis_wr_en, vis_wr_data;

   // request decode and fast wrap
   op_type          req_op;
   logic [8:0]      band1, band2, band3, draw_ext;
   logic            axis_col, go_inc, fast_ok, q_ok;
   logic [CW-1:0]   cur_v, new_v, fast_col, fast_row;
   logic [SW-1:0]   cur_size;
   logic [KW-1:0]   v_k, s_k, v_inc, v_dec, fast_val;
   logic [DW-1:0]   slow_dvd;
   logic [AW-1:0]   q_addr, acc_addr;

   always_comb begin
      req_op   = op_type'(req_if.operation);
      draw_ext = 9'(req_if.draw);
      band1    = 9'(pct_down_ff);
      band2    = band1 + 9'(pct_up_ff);
      band3    = band2 + 9'(pct_left_ff);
      axis_col = !(draw_ext < band2);
      go_inc   = (draw_ext < band1) || !(draw_ext < band3);
      cur_v    = axis_col ? walker_col_ff : walker_row_ff;
      cur_size = axis_col ? eff_w : eff_h;
      v_k      = KW'(cur_v);
      s_k      = KW'(cur_size);
      v_inc    = v_k + 1'b1;
      v_dec    = v_k - 1'b1;
      if (go_inc) begin
         fast_ok  = (v_inc <= s_k);
         fast_val = (v_inc == s_k) ? '0 : v_inc;
         slow_dvd = DW'(v_inc);
      end else begin
         slow_dvd = DW'(v_dec);
         if (cur_v == '0) begin
            fast_ok  = 1'b1;
            fast_val = s_k - 1'b1;
         end else begin
            fast_ok  = (v_dec < s_k);
            fast_val = v_dec;
         end
      end
      new_v    = CW'(fast_val);
      fast_col = axis_col ? new_v : walker_col_ff;
      fast_row = axis_col ? walker_row_ff : new_v;
      q_ok     = (QW'(req_if.cell_col) < QW'(MAX_SIDE)) &&
                 (QW'(req_if.cell_row) < QW'(MAX_SIDE));
      q_addr   = cell_addr(CW'(req_if.cell_col), CW'(req_if.cell_row));
      acc_addr = (req_op == OP_STEP) ? cell_addr(fast_col, fast_row) : q_addr;
   end

   // restoring remainder step, one dividend bit per cycle
   always_comb begin
      sh_col     = {rem_col_ff, dvd_col_ff[DW-1]};
      sh_row     = {rem_row_ff, dvd_row_ff[DW-1]};
      rem_col_nx = (sh_col >= {1'b0, eff_w}) ? SW'(sh_col - {1'b0, eff_w}) : sh_col[SW-1:0];
      rem_row_nx = (sh_row >= {1'b0, eff_h}) ? SW'(sh_row - {1'b0, eff_h}) : sh_row[SW-1:0];
      div_last   = (iter_ff == ITW'(DW - 1));
      iter_in    = acc ? '0 : ((state_ff == ST_DIVIDE) ? iter_ff + 1'b1 : iter_ff);
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_if.ready  = 1'b0;
      acc           = 1'b0;
      fin_fire      = 1'b0;
      clr_last      = (clr_ff == AW'(CELLS - 1));
      out_free      = !rsp_valid_ff || rsp_if.ready;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               acc = 1'b1;
               case (req_op)
                  OP_STEP:    state_in = fast_ok ? ST_FINISH : ST_DIVIDE;
                  OP_RESTART: state_in = ST_DIVIDE;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_last) state_in = (op_ff == OP_RESTART) ? ST_FINISH : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               fin_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         iter_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         iter_ff <= iter_in;
      end
   end

   assign clr_in = (state_ff == ST_CLEAR && !clr_last) ? clr_ff + 1'b1 : clr_ff;

   // item capture and remainder datapath
   always_ff @(posedge clock) begin
      if (acc) begin
         op_ff       <= req_op;
         blk_ff      <= req_if.cell_blocked;
         q_ok_ff     <= q_ok;
         axis_col_ff <= axis_col;
         addr_ff     <= acc_addr;
         tgt_col_ff  <= fast_col;
         tgt_row_ff  <= fast_row;
         rem_col_ff  <= '0;
         rem_row_ff  <= '0;
         if (req_op == OP_RESTART) begin
            dvd_col_ff <= DW'(start_col_ff);
            dvd_row_ff <= DW'(start_row_ff);
         end else begin
            dvd_col_ff <= axis_col ? slow_dvd : '0;
            dvd_row_ff <= axis_col ? '0 : slow_dvd;
         end
      end else if (state_ff == ST_DIVIDE) begin
         dvd_col_ff <= {dvd_col_ff[DW-2:0], 1'b0};
         dvd_row_ff <= {dvd_row_ff[DW-2:0], 1'b0};
         rem_col_ff <= rem_col_nx;
         rem_row_ff <= rem_row_nx;
         if (div_last) begin
            // the axis a step leaves alone keeps its coordinate as it is
            if (op_ff == OP_RESTART) begin
               tgt_col_ff <= CW'(rem_col_nx);
               tgt_row_ff <= CW'(rem_row_nx);
            end else if (axis_col_ff) begin
               tgt_col_ff <= CW'(rem_col_nx);
               tgt_row_ff <= walker_row_ff;
               addr_ff    <= cell_addr(CW'(rem_col_nx), walker_row_ff);
            end else begin
               tgt_col_ff <= walker_col_ff;
               tgt_row_ff <= CW'(rem_row_nx);
               addr_ff    <= cell_addr(walker_col_ff, CW'(rem_row_nx));
            end
         end
      end
   end

   // item completion
   logic                  end_now, won_now, moved, qb, qv, at_origin, tgt_origin;
   logic [COUNT_BITS-1:0] mc_inc;

   always_comb begin
      walker_col_in  = walker_col_ff;
      walker_row_in  = walker_row_ff;
      move_count_in  = move_count_ff;
      goal_in        = goal_ff;
      ended_in       = ended_ff;
      ended_total_in = ended_total_ff;
      won_total_in   = won_total_ff;
      end_now        = 1'b0;
      won_now        = 1'b0;
      moved          = 1'b0;
      qb             = 1'b0;
      qv             = 1'b0;
      obs_wr_en      = 1'b0;
      vis_wr_en      = 1'b0;
      at_origin      = (walker_col_ff == '0) && (walker_row_ff == '0);
      tgt_origin     = (tgt_col_ff == '0) && (tgt_row_ff == '0);
      mc_inc         = sat_inc(move_count_ff);
      case (op_ff)
         OP_WRITE_OBSTACLE: obs_wr_en = q_ok_ff;
         OP_STEP: begin
            if (!ended_ff) begin
               if (at_origin) begin
                  end_now = 1'b1;
                  won_now = 1'b1;
               end else if (LW'(move_count_ff) >= LW'(step_limit_ff)) begin
                  end_now = 1'b1;
               end else if (!obs_rd_ff) begin
                  moved         = 1'b1;
                  vis_wr_en     = 1'b1;
                  walker_col_in = tgt_col_ff;
                  walker_row_in = tgt_row_ff;
                  move_count_in = mc_inc;
                  if (tgt_origin) begin
                     end_now = 1'b1;
                     won_now = 1'b1;
                  end else if (LW'(mc_inc) >= LW'(step_limit_ff)) begin
                     end_now = 1'b1;
                  end
               end
            end
         end
         OP_RESTART: begin
            walker_col_in = tgt_col_ff;
            walker_row_in = tgt_row_ff;
            move_count_in = '0;
            goal_in       = 1'b0;
            ended_in      = 1'b0;
         end
         OP_QUERY: begin
            qb = q_ok_ff & obs_rd_ff;
            qv = q_ok_ff & vis_rd_ff;
         end
         default: ;
      endcase
      if (end_now) begin
         ended_in       = 1'b1;
         ended_total_in = sat_inc(ended_total_ff);
         if (won_now) begin
            goal_in      = 1'b1;
            won_total_in = sat_inc(won_total_ff);
         end
      end
      rsp_data_in.col_now       = CELL_W'(walker_col_in);
      rsp_data_in.row_now       = CELL_W'(walker_row_in);
      rsp_data_in.moved         = moved;
      rsp_data_in.reached_goal  = goal_in;
      rsp_data_in.walk_over     = ended_in;
      rsp_data_in.moves_made    = OUT_CNT_W'(move_count_in);
      rsp_data_in.walks_ended   = OUT_CNT_W'(ended_total_in);
      rsp_data_in.walks_won     = OUT_CNT_W'(won_total_in);
      rsp_data_in.query_blocked = qb;
      rsp_data_in.query_visited = qv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walker_col_ff  <= WALKER_COL_RST;
         walker_row_ff  <= WALKER_ROW_RST;
         move_count_ff  <= '0;
         goal_ff        <= 1'b0;
         ended_ff       <= 1'b0;
         ended_total_ff <= '0;
         won_total_ff   <= '0;
      end else if (fin_fire) begin
         walker_col_ff  <= walker_col_in;
         walker_row_ff  <= walker_row_in;
         move_count_ff  <= move_count_in;
         goal_ff        <= goal_in;
         ended_ff       <= ended_in;
         ended_total_ff <= ended_total_in;
         won_total_ff   <= won_total_in;
      end
   end

   // output register
   assign rsp_valid_in = fin_fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (fin_fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.col_now       = rsp_data_ff.col_now;
   assign rsp_if.row_now       = rsp_data_ff.row_now;
   assign rsp_if.moved         = rsp_data_ff.moved;
   assign rsp_if.reached_goal  = rsp_data_ff.reached_goal;
   assign rsp_if.walk_over     = rsp_data_ff.walk_over;
   assign rsp_if.moves_made    = rsp_data_ff.moves_made;
   assign rsp_if.walks_ended   = rsp_data_ff.walks_ended;
   assign rsp_if.walks_won     = rsp_data_ff.walks_won;
   assign rsp_if.query_blocked = rsp_data_ff.query_blocked;
   assign rsp_if.query_visited = rsp_data_ff.query_visited;

   // memory ports, the clearing pass owns both write ports after reset
   always_comb begin
      rd_addr     = (state_ff == ST_IDLE) ? acc_addr : addr_ff;
      obs_wr_addr = addr_ff;
      obs_wr_data = blk_ff;
      vis_wr_addr = cell_addr(walker_col_ff, walker_row_ff);
      vis_wr_data = 1'b1;
      if (state_ff == ST_CLEAR) begin
         obs_wr_addr = clr_ff;
         obs_wr_data = 1'b0;
         vis_wr_addr = clr_ff;
         vis_wr_data = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_CLEAR) || (fin_fire && obs_wr_en)) begin
         obs_mem[obs_wr_addr] <= obs_wr_data;
      end
      obs_rd_ff <= obs_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_CLEAR) || (fin_fire && vis_wr_en)) begin
         vis_mem[vis_wr_addr] <= vis_wr_data;
      end
      vis_rd_ff <= vis_mem[rd_addr];
   end

endmodule

FILE: rtl/tgrw_checker.sv
// ---------------------------------------------------------------------------
// tgrw_checker
// port-level assertions on the torus grid random walker
// ---------------------------------------------------------------------------
`include "torus_grid_random_walker_macros.svh"

module tgrw_checker import tgrw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CELL_W-1:0]    col_now,
   input logic [CELL_W-1:0]    row_now,
   input logic                 moved,
   input logic                 reached_goal,
   input logic                 walk_over,
   input logic [OUT_CNT_W-1:0] moves_made,
   input logic                 query_blocked,
   input logic                 query_visited
);

   // the clearing pass keeps the request side closed
   `TGRW_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready, "ready during clear")

   // an accepted item drops ready, so items are never taken back to back
   `TGRW_ASSERT(a_item_gap, clock, reset, req_valid && req_ready |=> !req_ready,
                "item accepted in back to back cycles")

   `TGRW_ASSERT(a_goal_ends_walk, clock, reset, rsp_valid && reached_goal |-> walk_over,
                "goal reached without walk over")

   `TGRW_ASSERT(a_move_not_query, clock, reset,
                rsp_valid && moved |-> !query_blocked && !query_visited,
                "move result carries query bits")

   `TGRW_ASSERT(a_rsp_hold, clock, reset,
                rsp_valid && !rsp_ready |=> rsp_valid && $stable(col_now) &&
                $stable(row_now) && $stable(moves_made),
                "stalled result changed")

endmodule

bind torus_grid_random_walker tgrw_checker u_tgrw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .col_now       (rsp_if.col_now),
   .row_now       (rsp_if.row_now),
   .moved         (rsp_if.moved),
   .reached_goal  (rsp_if.reached_goal),
   .walk_over     (rsp_if.walk_over),
   .moves_made    (rsp_if.moves_made),
   .query_blocked (rsp_if.query_blocked),
   .query_visited (rsp_if.query_visited)
);
